// ===== src/jsu_pkg.sv =====
// jsu_pkg: types and constants shared by the json string unescaper
// used by jsu_decode and json_string_unescaper_unit
`default_nettype none

package jsu_pkg;

    localparam logic [7:0]  CH_BACKSLASH = 8'h5C;
    localparam logic [7:0]  CH_U         = 8'h75;
    localparam logic [7:0]  CH_B         = 8'h62;
    localparam logic [7:0]  CH_F         = 8'h66;
    localparam logic [7:0]  CH_N         = 8'h6E;
    localparam logic [7:0]  CH_R         = 8'h72;
    localparam logic [7:0]  CH_T         = 8'h74;
    localparam logic [7:0]  CODE_BS      = 8'h08;
    localparam logic [7:0]  CODE_FF      = 8'h0C;
    localparam logic [7:0]  CODE_LF      = 8'h0A;
    localparam logic [7:0]  CODE_SPACE   = 8'h20;

    localparam logic [15:0] UTF8_MAX_1B  = 16'h007F;
    localparam logic [15:0] UTF8_MAX_2B  = 16'h07FF;

    localparam logic [15:0] LIMIT_RESET  = 16'(12 * 1024);

    // register index taken from paddr[2]
    localparam logic        REG_OUTPUT_LIMIT = 1'b0;

    localparam logic [2:0]  HEX_NONE     = 3'd0;
    localparam logic [2:0]  HEX_FIRST    = 3'd1;
    localparam logic [2:0]  HEX_FINAL    = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
    } t_out_beat;

    // per-string decode state, except the byte count
    typedef struct packed {
        logic        escape_pending;
        logic [2:0]  hex_digits_seen;
        logic        hex_all_valid;
        logic [15:0] code_value;
        logic        halted;
    } t_state;

    localparam t_state STATE_CLEAR = '{
        escape_pending:  1'b0,
        hex_digits_seen: HEX_NONE,
        hex_all_valid:   1'b1,
        code_value:      16'h0000,
        halted:          1'b0
    };

    // decoded bytes of one input beat
    typedef struct packed {
        logic [1:0] n_bytes;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } t_run;

endpackage

`default_nettype wire

// ===== src/jsu_stream_if.sv =====
// jsu_stream_if: valid/ready channel carrying one payload beat of type T
// no dependencies; payload types come from jsu_pkg at the instance
`default_nettype none

interface jsu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/jsu_decode.sv =====
// jsu_decode: combinational decode of one raw byte against the string state
// depends on jsu_pkg
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  wire t_state     i_state,
    input  wire logic       i_at_limit,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_state          o_state,
    output t_run            o_run
);

    logic       hex_ok;
    logic [3:0] hex_digit;
    logic [15:0] code_next;

    always_comb begin
        hex_ok    = 1'b1;
        hex_digit = 4'h0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_digit = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            hex_digit = 4'(i_byte - 8'h57);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            hex_digit = 4'(i_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign code_next = {i_state.code_value[11:0], hex_digit};

    always_comb begin
        o_state = i_state;
        o_run   = '0;

        if (i_state.halted) begin
            // rest of string is dropped
        end else if (i_state.hex_digits_seen != HEX_NONE) begin
            if (!hex_ok) begin
                o_state.hex_all_valid = 1'b0;
            end else begin
                o_state.code_value = code_next;
            end
            if (i_state.hex_digits_seen >= HEX_FINAL) begin
                if (o_state.hex_all_valid) begin
                    if (o_state.code_value <= UTF8_MAX_1B) begin
                        o_run.n_bytes = 2'd1;
                        o_run.byte0   = o_state.code_value[7:0];
                    end else if (o_state.code_value <= UTF8_MAX_2B) begin
                        o_run.n_bytes = 2'd2;
                        o_run.byte0   = {3'b110, o_state.code_value[10:6]};
                        o_run.byte1   = {2'b10, o_state.code_value[5:0]};
                    end else begin
                        o_run.n_bytes = 2'd3;
                        o_run.byte0   = {4'b1110, o_state.code_value[15:12]};
                        o_run.byte1   = {2'b10, o_state.code_value[11:6]};
                        o_run.byte2   = {2'b10, o_state.code_value[5:0]};
                    end
                end
                o_state.hex_digits_seen = HEX_NONE;
                o_state.hex_all_valid   = 1'b1;
                o_state.code_value      = 16'h0000;
            end else begin
                o_state.hex_digits_seen = i_state.hex_digits_seen + 3'd1;
            end
        end else if (i_state.escape_pending) begin
            o_state.escape_pending = 1'b0;
            if (i_byte == CH_U) begin
                o_state.hex_digits_seen = HEX_FIRST;
                o_state.hex_all_valid   = 1'b1;
                o_state.code_value      = 16'h0000;
            end else begin
                o_run.n_bytes = 2'd1;
                case (i_byte)
                    CH_B:    o_run.byte0 = CODE_BS;
                    CH_F:    o_run.byte0 = CODE_FF;
                    CH_N:    o_run.byte0 = CODE_LF;
                    CH_R:    o_run.byte0 = CODE_LF;
                    CH_T:    o_run.byte0 = CODE_SPACE;
                    default: o_run.byte0 = i_byte;
                endcase
            end
        end else if (i_at_limit) begin
            o_state.halted = 1'b1;
        end else if (i_byte == CH_BACKSLASH && !i_last) begin
            o_state.escape_pending = 1'b1;
        end else begin
            o_run.n_bytes = 2'd1;
            o_run.byte0   = i_byte;
        end

        if (i_last) begin
            o_state = STATE_CLEAR;
        end
    end

endmodule

`default_nettype wire

// ===== src/json_string_unescaper_unit.sv =====
// json_string_unescaper_unit: top level, state registers, run buffer, APB register
// depends on jsu_pkg, jsu_stream_if, jsu_decode
//
//  channel   dir  payload                                      handshake
//  i_in      in   in_byte[7:0], string_last                    valid/ready
//  o_out     out  out_byte[7:0], byte_valid, run_last,         valid/ready
//                 string_end
//  apb       in   output_limit at 0x0 (paddr[2] selects)       psel/penable, pready=1
//
// one input beat per cycle while the run buffer has room; a beat is decoded in the
// cycle it is accepted and its 0..3 output beats, or an end marker, are loaded
// into a run buffer that drains one per cycle while o_out is ready. a unicode escape
// yields 1..3 bytes at its fourth hex digit. i_in.ready is high when the buffer is
// empty or its last beat leaves in the same cycle. synchronous active-low reset
// clears all control state and sets output_limit to 12288; no clearing pass.
`default_nettype none

module json_string_unescaper_unit
    import jsu_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    jsu_stream_if.sink       i_in,
    jsu_stream_if.source     o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [15:0]           r_limit;
    t_state                r_state;
    t_state                n_state;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS:0]   count_sum;
    logic [CMP_W-1:0]      count_ext;
    logic [CMP_W-1:0]      limit_ext;
    logic                  at_limit;
    t_run                  run;

    logic [7:0]            r_bytes [3];
    logic [1:0]            r_idx;
    logic [1:0]            r_left;
    logic                  r_bv;
    logic                  r_end;

    logic                  in_fire;
    logic                  out_fire;
    logic                  load;
    t_in_beat              in_beat;

    // apb register
    assign pready = 1'b1;
    assign prdata = {16'h0000, (paddr[2] == REG_OUTPUT_LIMIT) ? r_limit : 16'h0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_OUTPUT_LIMIT) begin
            r_limit <= pwdata[15:0];
        end
    end

    assign in_beat   = i_in.data;
    assign count_ext = CMP_W'(r_count);
    assign limit_ext = CMP_W'(r_limit);
    assign at_limit  = count_ext >= limit_ext;

    jsu_decode u_decode (
        .i_state    (r_state),
        .i_at_limit (at_limit),
        .i_byte     (in_beat.in_byte),
        .i_last     (in_beat.string_last),
        .o_state    (n_state),
        .o_run      (run)
    );

    // saturating decoded-byte count
    assign count_sum = {1'b0, r_count} + (COUNT_BITS+1)'(run.n_bytes);
    always_comb begin
        if (in_beat.string_last) begin
            n_count = '0;
        end else if (count_sum[COUNT_BITS]) begin
            n_count = COUNT_MAX;
        end else begin
            n_count = count_sum[COUNT_BITS-1:0];
        end
    end

    assign out_fire   = o_out.valid && o_out.ready;
    assign i_in.ready = (r_left == 2'd0) || (r_left == 2'd1 && o_out.ready);
    assign in_fire    = i_in.valid && i_in.ready;
    assign load       = in_fire && (run.n_bytes != 2'd0 || in_beat.string_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
            r_count <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // run buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
            r_idx  <= 2'd0;
        end else if (load) begin
            r_left <= (run.n_bytes == 2'd0) ? 2'd1 : run.n_bytes;
            r_idx  <= 2'd0;
        end else if (out_fire) begin
            r_left <= r_left - 2'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    // run buffer payload; an empty end marker carries a zero byte
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes[0] <= run.byte0;
            r_bytes[1] <= run.byte1;
            r_bytes[2] <= run.byte2;
            r_bv       <= run.n_bytes != 2'd0;
            r_end      <= in_beat.string_last;
        end
    end

    assign o_out.valid           = r_left != 2'd0;
    assign o_out.data.out_byte   = r_bytes[r_idx];
    assign o_out.data.byte_valid = r_bv;
    assign o_out.data.run_last   = r_left == 2'd1;
    assign o_out.data.string_end = r_end && r_left == 2'd1;

endmodule

`default_nettype wire

// ===== tb/sv/json_string_unescaper_unit_tb.sv =====
// json_string_unescaper_unit_tb: self-checking bench for the json string unescaper
// depends on jsu_pkg, jsu_stream_if and json_string_unescaper_unit
// drives escaped string bytes and limit writes, predicts every decoded beat and compares
`default_nettype none

module json_string_unescaper_unit_tb;
    import jsu_pkg::*;

    localparam logic [7:0] SIMPLE_ESC [8] = '{8'h22, CH_BACKSLASH, 8'h2F, CH_B,
                                              CH_F, CH_N, CH_R, CH_T};

    // keeps its own copy of the decode state and the decoded beats still due
    class json_decode_tracker;
        logic [15:0] limit;
        logic        esc_open;
        logic [2:0]  hex_pos;
        logic        hex_ok;
        logic [15:0] code;
        logic [15:0] count;
        logic        stopped;
        t_out_beat   decoded_due [$];
        int          fed_bytes;
        int          mismatches;

        function new();
            limit      = LIMIT_RESET;
            fed_bytes  = 0;
            mismatches = 0;
            clear_string();
        endfunction

        function void clear_string();
            esc_open = 1'b0;
            hex_pos  = HEX_NONE;
            hex_ok   = 1'b1;
            code     = 16'h0000;
            count    = 16'h0000;
            stopped  = 1'b0;
        endfunction

        function void take_raw_byte(t_in_beat beat);
            logic [7:0] run [$];
            logic [7:0] b;
            logic [3:0] nib;
            logic       is_hex;
            t_out_beat  o;
            b = beat.in_byte;
            fed_bytes++;
            if (stopped) begin
                // rest of the string is dropped
            end else if (hex_pos != HEX_NONE) begin
                is_hex = 1'b1;
                nib    = 4'h0;
                if (b >= "0" && b <= "9") nib = 4'(b - "0");
                else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
                else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
                else is_hex = 1'b0;
                if (!is_hex) hex_ok = 1'b0;
                else code = {code[11:0], nib};
                if (hex_pos >= HEX_FINAL) begin
                    if (hex_ok) begin
                        if (code <= UTF8_MAX_1B) begin
                            run.insert(run.size(), code[7:0]);
                        end else if (code <= UTF8_MAX_2B) begin
                            run.insert(run.size(), {3'b110, code[10:6]});
                            run.insert(run.size(), {2'b10, code[5:0]});
                        end else begin
                            run.insert(run.size(), {4'b1110, code[15:12]});
                            run.insert(run.size(), {2'b10, code[11:6]});
                            run.insert(run.size(), {2'b10, code[5:0]});
                        end
                    end
                    hex_pos = HEX_NONE;
                    hex_ok  = 1'b1;
                    code    = 16'h0000;
                end else begin
                    hex_pos++;
                end
            end else if (esc_open) begin
                esc_open = 1'b0;
                if (b == CH_U) begin
                    hex_pos = HEX_FIRST;
                    hex_ok  = 1'b1;
                    code    = 16'h0000;
                end else begin
                    case (b)
                        CH_B:    run.insert(run.size(), CODE_BS);
                        CH_F:    run.insert(run.size(), CODE_FF);
                        CH_N:    run.insert(run.size(), CODE_LF);
                        CH_R:    run.insert(run.size(), CODE_LF);
                        CH_T:    run.insert(run.size(), CODE_SPACE);
                        default: run.insert(run.size(), b);
                    endcase
                end
            end else if (count >= limit) begin
                stopped = 1'b1;
            end else if (b == CH_BACKSLASH && !beat.string_last) begin
                esc_open = 1'b1;
            end else begin
                run.insert(run.size(), b);
            end

            foreach (run[i]) if (count != 16'hFFFF) count++;

            if (run.size() == 0 && beat.string_last) begin
                o = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1, string_end: 1'b1};
                decoded_due.insert(decoded_due.size(), o);
            end
            foreach (run[i]) begin
                o.out_byte   = run[i];
                o.byte_valid = 1'b1;
                o.run_last   = (i == run.size() - 1);
                o.string_end = (i == run.size() - 1) && beat.string_last;
                decoded_due.insert(decoded_due.size(), o);
            end
            if (beat.string_last) clear_string();
        endfunction

        function void match_decoded(t_out_beat got);
            t_out_beat want;
            if (decoded_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat: got byte=%02h valid=%b run_last=%b end=%b",
                         $time, got.out_byte, got.byte_valid, got.run_last, got.string_end);
                return;
            end
            want = decoded_due.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.run_last !== want.run_last || got.string_end !== want.string_end) begin
                mismatches++;
                $display("%0t: beat mismatch: expected byte=%02h valid=%b run_last=%b end=%b",
                         $time, want.out_byte, want.byte_valid, want.run_last, want.string_end);
                $display("%0t:                got      byte=%02h valid=%b run_last=%b end=%b",
                         $time, got.out_byte, got.byte_valid, got.run_last, got.string_end);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int src_idle;
    int sink_stall;

    json_decode_tracker sb;

    jsu_stream_if #(.T(t_in_beat))  in_ch ();
    jsu_stream_if #(.T(t_out_beat)) out_ch ();

    json_string_unescaper_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.match_decoded(out_ch.data);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{in_byte: b, string_last: last};
        do @(posedge i_clk); while (!in_ch.ready);
        sb.take_raw_byte(in_ch.data);
        @(negedge i_clk);
    endtask

    task automatic play_string(input logic [7:0] s [$]);
        foreach (s[i]) send_byte(s[i], i == s.size() - 1);
    endtask

    // sender holds off until every due beat is out and the run buffer has emptied
    task automatic wait_for_quiet();
        in_ch.valid <= 1'b0;
        while (sb.decoded_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_OUTPUT_LIMIT, 2'b00};
        pwdata  <= {16'h0000, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.limit = v;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        logic [7:0]  str [$];
        logic [15:0] ucode;
        logic [3:0]  nib;
        logic [7:0]  ch;
        int          phase;
        int          base;
        int          pick;

        sb           = new();
        src_idle     = 0;
        sink_stall   = 0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // byte extremes, the b, f, n, r and t escapes, surrogate code, trailing backslash,
        // and a unicode escape cut short by the end of the string
        str = '{8'h00, CH_BACKSLASH, CH_B, CH_BACKSLASH, CH_F, CH_BACKSLASH, CH_N,
                CH_BACKSLASH, CH_R, CH_BACKSLASH, CH_T};
        play_string(str);
        str = '{CH_BACKSLASH, CH_U, "D", "8", "0", "0", 8'hFF, CH_BACKSLASH};
        play_string(str);
        str = '{CH_BACKSLASH, CH_U, "0", "7", "g"};
        play_string(str);

        for (phase = 0; phase < 4; phase++) begin
            wait_for_quiet();
            case (phase)
                0: begin
                    src_idle = 0;  sink_stall = 0;  write_limit(16'hFFFF);
                end
                1: begin
                    src_idle = 80; sink_stall = 0;  write_limit(16'd1);
                end
                2: begin
                    src_idle = 0;  sink_stall = 80; write_limit(16'd9);
                end
                default: begin
                    src_idle = 30; sink_stall = 30; write_limit(16'd2);
                end
            endcase
            base = sb.fed_bytes;
            while (sb.fed_bytes < base + 20) begin
                str.delete();
                if ($urandom_range(99) < 10) begin
                    repeat ($urandom_range(1, 10))
                        str.insert(str.size(), 8'($urandom_range(255)));
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        pick = $urandom_range(99);
                        if (pick < 35) begin
                            str.insert(str.size(), 8'($urandom_range(255)));
                        end else if (pick < 60) begin
                            str.insert(str.size(), CH_BACKSLASH);
                            pick = $urandom_range(9);
                            if (pick < 8) str.insert(str.size(), SIMPLE_ESC[pick]);
                            else str.insert(str.size(), 8'($urandom_range(255)));
                        end else begin
                            str.insert(str.size(), CH_BACKSLASH);
                            str.insert(str.size(), CH_U);
                            case ($urandom_range(2))
                                0:       ucode = 16'($urandom_range(16'h0000, 16'h007F));
                                1:       ucode = 16'($urandom_range(16'h0080, 16'h07FF));
                                default: ucode = 16'($urandom_range(16'h0800, 16'hFFFF));
                            endcase
                            for (int k = 0; k < 4; k++) begin
                                nib = ucode[15 - 4 * k -: 4];
                                if (nib < 10) ch = "0" + nib;
                                else if ($urandom_range(1)) ch = "A" + nib - 8'd10;
                                else ch = "a" + nib - 8'd10;
                                // occasionally spoil a digit
                                if ($urandom_range(99) < 8) ch = 8'($urandom_range(255));
                                str.insert(str.size(), ch);
                            end
                        end
                    end
                    if ($urandom_range(99) < 15) str.insert(str.size(), CH_BACKSLASH);
                    if ($urandom_range(99) < 15) begin
                        repeat ($urandom_range(1, 3))
                            if (str.size() > 1) str.delete(str.size() - 1);
                    end
                end
                play_string(str);
            end
        end

        wait_for_quiet();
        if (sb.mismatches == 0 && sb.decoded_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
